// ===== hdl/mcsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsr_pkg
// Types and constants shared by the machine-mode CSR unit.
// ----------------------------------------------------------------------------
package mcsr_pkg;

   typedef enum logic [2:0] {
      OP_READ    = 3'd0,
      OP_WRITE   = 3'd1,
      OP_TRAP    = 3'd2,
      OP_EBREAK  = 3'd3,
      OP_ECALL   = 3'd4,
      OP_ILLEGAL = 3'd5,
      OP_MRET    = 3'd6,
      OP_RETIRE  = 3'd7
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [11:0] csr_address;
      logic [31:0] write_data;
      logic        is_interrupt;
      logic [30:0] cause_code;
      logic [31:0] current_pc;
      logic        current_mode;
      logic [31:0] faulting_instruction;
      logic [7:0]  retire_count;
      logic [63:0] cycle_value;
      logic [63:0] time_value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        status;
      logic        redirect;
      logic [31:0] next_pc;
      logic        target_mode;
   } rsp_type;

   typedef struct packed {
      logic [31:0] fcsr;
      logic [31:0] mstatus;
      logic [31:0] mtvec;
      logic [31:0] mie;
      logic [31:0] mip;
      logic [31:0] mcounteren;
      logic [31:0] mscratch;
      logic [31:0] mepc;
      logic [31:0] mcause;
      logic [31:0] mtval;
      logic [63:0] instret;
   } csr_state_type;

   // CSR addresses
   localparam logic [11:0] CSR_FFLAGS     = 12'h001;
   localparam logic [11:0] CSR_FRM        = 12'h002;
   localparam logic [11:0] CSR_FCSR       = 12'h003;
   localparam logic [11:0] CSR_MSTATUS    = 12'h300;
   localparam logic [11:0] CSR_MISA       = 12'h301;
   localparam logic [11:0] CSR_MEDELEG    = 12'h302;
   localparam logic [11:0] CSR_MIDELEG    = 12'h303;
   localparam logic [11:0] CSR_MIE        = 12'h304;
   localparam logic [11:0] CSR_MTVEC      = 12'h305;
   localparam logic [11:0] CSR_MCOUNTEREN = 12'h306;
   localparam logic [11:0] CSR_MENVCFG    = 12'h30A;
   localparam logic [11:0] CSR_MSTATUSH   = 12'h310;
   localparam logic [11:0] CSR_MENVCFGH   = 12'h31A;
   localparam logic [11:0] CSR_MSCRATCH   = 12'h340;
   localparam logic [11:0] CSR_MEPC       = 12'h341;
   localparam logic [11:0] CSR_MCAUSE     = 12'h342;
   localparam logic [11:0] CSR_MTVAL      = 12'h343;
   localparam logic [11:0] CSR_MIP        = 12'h344;
   localparam logic [11:0] CSR_MTINST     = 12'h34A;
   localparam logic [11:0] CSR_MTVAL2     = 12'h34B;
   localparam logic [11:0] CSR_MSECCFG    = 12'h747;
   localparam logic [11:0] CSR_MSECCFGH   = 12'h757;
   localparam logic [11:0] CSR_CYCLE      = 12'hC00;
   localparam logic [11:0] CSR_TIME       = 12'hC01;
   localparam logic [11:0] CSR_INSTRET    = 12'hC02;
   localparam logic [11:0] CSR_HPM_LO     = 12'hC03;
   localparam logic [11:0] CSR_HPM_HI     = 12'hC1F;
   localparam logic [11:0] CSR_CYCLEH     = 12'hC80;
   localparam logic [11:0] CSR_TIMEH      = 12'hC81;
   localparam logic [11:0] CSR_INSTRETH   = 12'hC82;
   localparam logic [11:0] CSR_HPMH_LO    = 12'hC83;
   localparam logic [11:0] CSR_HPMH_HI    = 12'hC9F;
   localparam logic [11:0] CSR_MVENDORID  = 12'hF11;
   localparam logic [11:0] CSR_MARCHID    = 12'hF12;
   localparam logic [11:0] CSR_MIMPID     = 12'hF13;
   localparam logic [11:0] CSR_MHARTID    = 12'hF14;
   localparam logic [11:0] CSR_MCONFIGPTR = 12'hF15;

   localparam logic [31:0] MISA_VALUE    = 32'h4010_0101;
   localparam logic [31:0] MARCHID_VALUE = 32'h0000_0001;
   localparam logic [31:0] MSTATUS_WMASK = 32'h8022_00AA;
   localparam logic [31:0] MPP_MASK      = 32'h0000_1800;

   localparam int MIE_BIT  = 3;
   localparam int MPIE_BIT = 7;
   localparam int MPRV_BIT = 17;
   localparam int MPP_LSB  = 11;
   localparam int MPP_MSB  = 12;

   localparam logic [1:0]  MPP_USER    = 2'b00;
   localparam logic [1:0]  MPP_MACHINE = 2'b11;

   localparam logic [30:0] CAUSE_ILLEGAL    = 31'd2;
   localparam logic [30:0] CAUSE_BREAKPOINT = 31'd3;
   localparam logic [30:0] CAUSE_ECALL_U    = 31'd8;
   localparam logic [30:0] CAUSE_ECALL_M    = 31'd11;

   localparam logic [1:0]  MTVEC_VECTORED = 2'b01;

endpackage

// ===== hdl/mcsr_read_mux.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsr_read_mux
// CSR address decode and read data select; flags unknown addresses.
// ----------------------------------------------------------------------------
module mcsr_read_mux
   import mcsr_pkg::*;
(
   input  csr_state_type csr_state,
   input  logic [11:0]   csr_address,
   input  logic [63:0]   cycle_value,
   input  logic [63:0]   time_value,
   output logic [31:0]   read_data,
   output logic          read_illegal
);

   logic hpm_hit;

   assign hpm_hit = ((csr_address >= CSR_HPM_LO) && (csr_address <= CSR_HPM_HI)) ||
                    ((csr_address >= CSR_HPMH_LO) && (csr_address <= CSR_HPMH_HI));

   always_comb begin
      read_data    = '0;
      read_illegal = 1'b0;
      if (!hpm_hit) begin
         case (csr_address)
            CSR_FFLAGS:     read_data = {27'd0, csr_state.fcsr[4:0]};
            CSR_FRM:        read_data = {29'd0, csr_state.fcsr[7:5]};
            CSR_FCSR:       read_data = csr_state.fcsr;
            CSR_CYCLE:      read_data = cycle_value[31:0];
            CSR_TIME:       read_data = time_value[31:0];
            CSR_INSTRET:    read_data = csr_state.instret[31:0];
            CSR_CYCLEH:     read_data = cycle_value[63:32];
            CSR_TIMEH:      read_data = time_value[63:32];
            CSR_INSTRETH:   read_data = csr_state.instret[63:32];
            CSR_MARCHID:    read_data = MARCHID_VALUE;
            CSR_MSTATUS:    read_data = csr_state.mstatus;
            CSR_MISA:       read_data = MISA_VALUE;
            CSR_MIE:        read_data = csr_state.mie;
            CSR_MTVEC:      read_data = csr_state.mtvec;
            CSR_MCOUNTEREN: read_data = csr_state.mcounteren;
            CSR_MSCRATCH:   read_data = csr_state.mscratch;
            CSR_MEPC:       read_data = csr_state.mepc;
            CSR_MCAUSE:     read_data = csr_state.mcause;
            CSR_MTVAL:      read_data = csr_state.mtval;
            CSR_MIP:        read_data = csr_state.mip;
            CSR_MVENDORID, CSR_MIMPID, CSR_MHARTID, CSR_MCONFIGPTR,
            CSR_MEDELEG, CSR_MIDELEG, CSR_MSTATUSH, CSR_MTINST, CSR_MTVAL2,
            CSR_MENVCFG, CSR_MENVCFGH, CSR_MSECCFG, CSR_MSECCFGH:
               read_data = '0;
            default:        read_illegal = 1'b1;
         endcase
      end
   end

endmodule

// ===== hdl/machine_mode_csr_file_with_traps_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// machine_mode_csr_file_with_traps_unit
// RV32 machine/user CSR file: CSR read/write, trap entry, mret, instret.
//
//   channel | ports                            | content
//   req     | req_valid req_ready req_payload  | one CSR op, trap, mret or retire
//   rsp     | rsp_valid rsp_ready rsp_payload  | read data, status, redirect
//
// One request per cycle sustained while rsp_ready is high; a request goes
// through the input register, then the result register. CSR state commits
// on entry to the result register; each request sees all earlier updates.
// Synchronous reset clears all CSR state and both valid flags.
// With rsp_ready low the result holds and one more request is buffered.
// ----------------------------------------------------------------------------
module machine_mode_csr_file_with_traps_unit
   import mcsr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic          s1_valid_ff;
   req_type       s1_req_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   csr_state_type csr_ff;
   csr_state_type csr_in;
   rsp_type       rsp_in;

   logic          advance;
   logic          is_trap;
   logic [31:0]   rd_data;
   logic          rd_illegal;
   logic          wr_illegal;
   logic          trap_intr;
   logic [30:0]   trap_code;
   logic [31:0]   trap_base;
   logic [31:0]   trap_target;
   logic [31:0]   trap_mstatus;
   logic [1:0]    wr_mpp;
   logic [1:0]    cur_mpp;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   mcsr_read_mux u_read_mux (
      .csr_state    (csr_ff),
      .csr_address  (s1_req_ff.csr_address),
      .cycle_value  (s1_req_ff.cycle_value),
      .time_value   (s1_req_ff.time_value),
      .read_data    (rd_data),
      .read_illegal (rd_illegal)
   );

   // write legality
   always_comb begin
      case (s1_req_ff.csr_address)
         CSR_FFLAGS, CSR_FRM, CSR_FCSR, CSR_MSTATUS, CSR_MISA, CSR_MEDELEG,
         CSR_MIDELEG, CSR_MSTATUSH, CSR_MIE, CSR_MTVEC, CSR_MCOUNTEREN,
         CSR_MSCRATCH, CSR_MEPC, CSR_MCAUSE, CSR_MTVAL, CSR_MIP:
            wr_illegal = 1'b0;
         default:
            wr_illegal = 1'b1;
      endcase
   end

   // trap cause select
   always_comb begin
      is_trap   = 1'b1;
      trap_intr = 1'b0;
      trap_code = CAUSE_ILLEGAL;
      case (s1_req_ff.opcode)
         OP_TRAP: begin
            trap_intr = s1_req_ff.is_interrupt;
            trap_code = s1_req_ff.cause_code;
         end
         OP_EBREAK:  trap_code = CAUSE_BREAKPOINT;
         OP_ECALL:   trap_code = s1_req_ff.current_mode ? CAUSE_ECALL_M : CAUSE_ECALL_U;
         OP_ILLEGAL: trap_code = CAUSE_ILLEGAL;
         default:    is_trap = 1'b0;
      endcase
   end

   assign trap_base = {csr_ff.mtvec[31:2], 2'b00};
   assign trap_target = ((csr_ff.mtvec[1:0] == MTVEC_VECTORED) && trap_intr) ?
                        trap_base + {trap_code[29:0], 2'b00} : trap_base;

   always_comb begin
      trap_mstatus = csr_ff.mstatus & ~MPP_MASK;
      trap_mstatus[MPIE_BIT] = csr_ff.mstatus[MIE_BIT];
      trap_mstatus[MIE_BIT]  = 1'b0;
      if (s1_req_ff.current_mode) begin
         trap_mstatus[MPP_MSB:MPP_LSB] = MPP_MACHINE;
      end
   end

   assign wr_mpp  = ((s1_req_ff.write_data[MPP_MSB:MPP_LSB] == 2'b01) ||
                     (s1_req_ff.write_data[MPP_MSB:MPP_LSB] == 2'b10)) ?
                    MPP_USER : s1_req_ff.write_data[MPP_MSB:MPP_LSB];
   assign cur_mpp = csr_ff.mstatus[MPP_MSB:MPP_LSB];

   always_comb begin
      csr_in = csr_ff;
      rsp_in = '0;
      if (is_trap) begin
         csr_in.mcause  = {trap_intr, trap_code};
         csr_in.mepc    = s1_req_ff.current_pc;
         csr_in.mstatus = trap_mstatus;
         if (s1_req_ff.opcode == OP_ILLEGAL) begin
            csr_in.mtval = s1_req_ff.faulting_instruction;
         end
         rsp_in.redirect    = 1'b1;
         rsp_in.next_pc     = trap_target;
         rsp_in.target_mode = 1'b1;
      end
      case (s1_req_ff.opcode)
         OP_READ: begin
            rsp_in.read_data = rd_data;
            rsp_in.status    = rd_illegal;
         end
         OP_WRITE: begin
            rsp_in.status = wr_illegal;
            case (s1_req_ff.csr_address)
               CSR_FFLAGS: csr_in.fcsr[4:0] = s1_req_ff.write_data[4:0];
               CSR_FRM:    csr_in.fcsr[7:5] = s1_req_ff.write_data[2:0];
               CSR_FCSR:   csr_in.fcsr      = s1_req_ff.write_data;
               CSR_MSTATUS: begin
                  csr_in.mstatus = (csr_ff.mstatus & ~(MSTATUS_WMASK | MPP_MASK)) |
                                   (s1_req_ff.write_data & MSTATUS_WMASK);
                  csr_in.mstatus[MPP_MSB:MPP_LSB] = wr_mpp;
               end
               CSR_MIE:        csr_in.mie        = s1_req_ff.write_data;
               CSR_MTVEC:      csr_in.mtvec      = s1_req_ff.write_data;
               CSR_MCOUNTEREN: csr_in.mcounteren = s1_req_ff.write_data;
               CSR_MSCRATCH:   csr_in.mscratch   = s1_req_ff.write_data;
               CSR_MEPC:       csr_in.mepc       = s1_req_ff.write_data;
               CSR_MCAUSE:     csr_in.mcause     = s1_req_ff.write_data;
               CSR_MTVAL:      csr_in.mtval      = s1_req_ff.write_data;
               CSR_MIP:        csr_in.mip        = s1_req_ff.write_data;
               default:        csr_in = csr_ff;
            endcase
         end
         OP_MRET: begin
            csr_in.mstatus[MIE_BIT]  = csr_ff.mstatus[MPIE_BIT];
            csr_in.mstatus[MPIE_BIT] = 1'b1;
            if (cur_mpp != MPP_MACHINE) begin
               csr_in.mstatus[MPRV_BIT] = 1'b0;
            end
            csr_in.mstatus[MPP_MSB:MPP_LSB] = MPP_USER;
            rsp_in.redirect    = 1'b1;
            rsp_in.next_pc     = csr_ff.mepc;
            rsp_in.target_mode = (cur_mpp == MPP_MACHINE);
         end
         OP_RETIRE: begin
            csr_in.instret = csr_ff.instret + {56'd0, s1_req_ff.retire_count};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         csr_ff       <= '0;
      end else begin
         if (req_valid && req_ready) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            csr_ff       <= csr_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   a_mpp_legal: assert property (@(posedge clock) disable iff (reset)
      (csr_ff.mstatus[MPP_MSB:MPP_LSB] != 2'b01) &&
      (csr_ff.mstatus[MPP_MSB:MPP_LSB] != 2'b10))
      else $error("mstatus.mpp holds an unsupported mode");

   a_trap_clears_mie: assert property (@(posedge clock) disable iff (reset)
      (advance && is_trap) |=> !csr_ff.mstatus[MIE_BIT])
      else $error("trap entry left mstatus.mie set");

   a_redirect_no_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.redirect && rsp_ff.status))
      else $error("redirect result carries an illegal-CSR status");

   a_stall_buffered: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request port stalled without a full pipeline");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (csr_ff == $past(csr_ff)))
      else $error("CSR state changed without a committed request");

endmodule
